// ===== rtl/rlle_pkg.sv =====
`timescale 1ns / 1ps

package rlle_pkg;

    // Field widths
    localparam int PIXEL_W  = 8;
    localparam int OFFSET_W = 13;
    localparam int RUN_W    = 8;
    localparam int TAIL_W   = 7;

    // Default for the longest line in pixels
    localparam int MAX_LINE_WIDTH_DEF = 4096;

    // Limits on the run and literal lengths
    localparam logic [RUN_W-1:0]  RUN_MIN  = RUN_W'(3);
    localparam logic [RUN_W-1:0]  RUN_CAP  = RUN_W'(128);
    localparam logic [TAIL_W-1:0] TAIL_MIN = TAIL_W'(1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RUN  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TAIL = CFG_INDEX_W'(1);

    // One pixel can close and open three atoms and close the last one at line end
    localparam int MAX_RESULTS  = 7;
    localparam int BUNDLE_CNT_W = 3;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_LIT  = 2'd2
    } atom_mode_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] write_offset;
        logic [7:0]          write_byte;
        logic                line_done;
        logic [OFFSET_W-1:0] line_bytes;
    } out_item_t;

    // Effective limits after clamping the configuration registers
    typedef struct packed {
        logic [RUN_W-1:0]  run_lim;
        logic [TAIL_W-1:0] tail_lim;
    } limits_t;

    // All byte writes caused by one pixel, in order
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] item;
        logic [BUNDLE_CNT_W-1:0]     count;
    } bundle_t;

endpackage

// ===== rtl/rlle_config.sv =====
`timescale 1ns / 1ps

module rlle_config
    import rlle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output limits_t                limits
);

    logic [RUN_W-1:0]  max_run_reg;
    logic [TAIL_W-1:0] max_tail_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg  <= RUN_CAP;
            max_tail_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_RUN:  max_run_reg  <= cfg_data[RUN_W-1:0];
                CFG_MAX_TAIL: max_tail_reg <= cfg_data[TAIL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the limits into their legal ranges.
    always_comb
    begin
        if (max_run_reg < RUN_MIN)
            limits.run_lim = RUN_MIN;
        else if (max_run_reg > RUN_CAP)
            limits.run_lim = RUN_CAP;
        else
            limits.run_lim = max_run_reg;
        limits.tail_lim = (max_tail_reg < TAIL_MIN) ? TAIL_MIN : max_tail_reg;
    end

endmodule

// ===== rtl/rlle_core.sv =====
`timescale 1ns / 1ps

module rlle_core
    import rlle_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    output logic     pix_stall,
    input  in_item_t pix_item,
    input  limits_t  limits,
    input  logic     load_ok,
    output logic     load,
    output bundle_t  bundle
);

    localparam int CNT_W = $clog2(MAX_LINE_WIDTH);

    typedef struct packed {
        atom_mode_t          mode;
        logic [OFFSET_W-1:0] head_offset;
        logic [RUN_W-1:0]    length;
        logic [OFFSET_W-1:0] write_pointer;
        logic [PIXEL_W-1:0]  previous_pixel;
    } atom_state_t;

    typedef struct packed {
        atom_state_t st;
        logic [1:0]  n;
        out_item_t   r0;
        out_item_t   r1;
    } step_t;

    // Input register
    in_item_t in_reg;
    logic     in_valid_reg;

    // Encoder state
    atom_state_t                    atom_reg, atom_next;
    logic [1:0][PIXEL_W-1:0]        la_reg, la_next;
    logic [1:0]                     la_cnt_reg, la_cnt_next;
    logic [CNT_W-1:0]               line_cnt_reg, line_cnt_next;

    // Head byte of the open atom, if any
    function automatic step_t close_atom(atom_state_t s, logic done);
        step_t r;
        r    = '0;
        r.st = s;
        r.r0.write_offset = s.head_offset;
        r.r0.write_byte   = (s.mode == MODE_RUN) ? 8'(-s.length) : s.length;
        r.r0.line_done    = done;
        r.r0.line_bytes   = done ? s.write_pointer : '0;
        r.n = (s.mode == MODE_RUN || s.mode == MODE_LIT) ? 2'd1 : 2'd0;
        r.st.mode   = MODE_NONE;
        r.st.length = '0;
        return r;
    endfunction

    // Decide one pixel: extend the open atom, or close it and open a new one.
    function automatic step_t take_pixel(atom_state_t s, logic [PIXEL_W-1:0] c,
                                         logic triple, limits_t lim);
        step_t     r;
        step_t     cl;
        logic      do_open;
        out_item_t opened;
        r       = '0;
        r.st    = s;
        do_open = 1'b1;
        case (s.mode)
            MODE_RUN:
            begin
                if (c == s.previous_pixel && s.length < lim.run_lim)
                begin
                    r.st.length = s.length + RUN_W'(1);
                    do_open     = 1'b0;
                end
            end
            MODE_LIT:
            begin
                if (!triple && s.length < {1'b0, lim.tail_lim})
                begin
                    r.r0.write_offset   = s.write_pointer;
                    r.r0.write_byte     = c;
                    r.n                 = 2'd1;
                    r.st.write_pointer  = s.write_pointer + OFFSET_W'(1);
                    r.st.length         = s.length + RUN_W'(1);
                    r.st.previous_pixel = c;
                    do_open             = 1'b0;
                end
            end
            default: ;
        endcase
        if (do_open)
        begin
            cl   = close_atom(s, 1'b0);
            r.st = cl.st;
            r.n  = cl.n;
            r.r0 = cl.r0;
            opened              = '0;
            opened.write_offset = s.write_pointer + OFFSET_W'(1);
            opened.write_byte   = c;
            if (cl.n == 2'd0)
                r.r0 = opened;
            else
                r.r1 = opened;
            r.n                 = cl.n + 2'd1;
            r.st.head_offset    = s.write_pointer;
            r.st.write_pointer  = s.write_pointer + OFFSET_W'(2);
            r.st.length         = RUN_W'(1);
            r.st.mode           = triple ? MODE_RUN : MODE_LIT;
            r.st.previous_pixel = c;
        end
        return r;
    endfunction

    // Append a step's results to the bundle.
    function automatic bundle_t append(bundle_t b, step_t s);
        bundle_t o;
        o = b;
        if (s.n != 2'd0)
        begin
            o.item[o.count] = s.r0;
            o.count         = o.count + BUNDLE_CNT_W'(1);
        end
        if (s.n == 2'd2)
        begin
            o.item[o.count] = s.r1;
            o.count         = o.count + BUNDLE_CNT_W'(1);
        end
        return o;
    endfunction

    // Handshake on the pixel side
    assign load      = in_valid_reg && load_ok;
    assign pix_stall = in_valid_reg && !load_ok;

    // One pass over the registered pixel
    always_comb
    begin
        logic                    last;
        logic [PIXEL_W-1:0]      px;
        logic [PIXEL_W-1:0]      seq0;
        logic [PIXEL_W-1:0]      seq1;
        logic                    use1;
        logic                    triple0;
        step_t                   s;
        bundle_t                 b;

        px   = in_reg.pixel;
        last = in_reg.end_of_line || (line_cnt_reg == CNT_W'(MAX_LINE_WIDTH - 1));
        b    = '0;
        atom_next     = atom_reg;
        la_next       = la_reg;
        la_cnt_next   = la_cnt_reg;
        line_cnt_next = last ? '0 : line_cnt_reg + CNT_W'(1);
        seq0    = '0;
        seq1    = '0;
        use1    = 1'b0;
        triple0 = 1'b0;
        s       = '0;

        if (!last)
        begin
            if (la_cnt_reg != 2'd2)
            begin
                la_next[la_cnt_reg[0]] = px;
                la_cnt_next            = la_cnt_reg + 2'd1;
            end
            else
            begin
                triple0 = (la_reg[0] == la_reg[1]) && (la_reg[0] == px);
                s       = take_pixel(atom_reg, la_reg[0], triple0, limits);
                b       = append(b, s);
                atom_next  = s.st;
                la_next[0] = la_reg[1];
                la_next[1] = px;
            end
        end
        else
        begin
            // Flush the lookahead pixels, then the final pixel, then close.
            seq0    = (la_cnt_reg != 2'd0) ? la_reg[0] : px;
            seq1    = (la_cnt_reg == 2'd2) ? la_reg[1] : px;
            use1    = (la_cnt_reg == 2'd2);
            triple0 = use1 && (seq0 == seq1) && (seq0 == px);
            atom_next = atom_reg;
            if (la_cnt_reg != 2'd0)
            begin
                s = take_pixel(atom_next, seq0, triple0, limits);
                b = append(b, s);
                atom_next = s.st;
            end
            if (use1)
            begin
                s = take_pixel(atom_next, seq1, 1'b0, limits);
                b = append(b, s);
                atom_next = s.st;
            end
            s = take_pixel(atom_next, px, 1'b0, limits);
            b = append(b, s);
            atom_next = s.st;
            s = close_atom(atom_next, 1'b1);
            b = append(b, s);
            atom_next               = s.st;
            atom_next.head_offset   = '0;
            atom_next.write_pointer = '0;
            la_next                 = '0;
            la_cnt_next             = '0;
        end
        bundle = b;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pix_valid && !pix_stall)
            in_valid_reg <= 1'b1;
        else if (load)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && !pix_stall)
            in_reg <= pix_item;
    end

    // Encoder state advances with each processed pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_reg     <= '{mode: MODE_NONE, default: '0};
            la_reg       <= '0;
            la_cnt_reg   <= '0;
            line_cnt_reg <= '0;
        end
        else if (load)
        begin
            atom_reg     <= atom_next;
            la_reg       <= la_next;
            la_cnt_reg   <= la_cnt_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

endmodule

// ===== rtl/rlle_out.sv =====
`timescale 1ns / 1ps

module rlle_out
    import rlle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  bundle_t   bundle,
    output logic      load_ok,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    out_item_t [MAX_RESULTS-1:0] items_reg;
    logic [BUNDLE_CNT_W-1:0]     count_reg;
    logic [BUNDLE_CNT_W-1:0]     idx_reg;
    logic                        take;

    // Results leave one per cycle from the held bundle, unless the receiver stalls.
    assign res_valid = (idx_reg != count_reg);
    assign res_item  = items_reg[idx_reg];
    assign take      = res_valid && !res_stall;

    // A new bundle may enter when none is held, or as the last held result goes out.
    assign load_ok = !res_valid || (take && (idx_reg + BUNDLE_CNT_W'(1) == count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= bundle.count;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + BUNDLE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= bundle.item;
    end

endmodule

// ===== rtl/run_length_line_encoder.sv =====
`timescale 1ns / 1ps

// Run-length line encoder: takes one colour index per request and produces
// byte writes (offset, byte) of the encoded line, in order. A pixel is held
// in an input register and decided against a two-pixel lookahead; its byte
// writes (none to two, up to seven for the last pixel of a line) are loaded
// together into a result register and leave at one per cycle while the
// receiver does not stall. A pixel can be accepted every cycle while results
// are drained as fast as they are made; otherwise the output port, at one
// byte write per cycle, sets the rate, and a new pixel is loaded only once
// the last held write goes out. The first write of a line is made once its
// third pixel is in the input register, or its last pixel when the line
// is shorter than three pixels. Configuration is taken at any time with
// ready held high and must only be changed while the encoder is idle.
module run_length_line_encoder
    import rlle_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  in_item_t               pix_item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output out_item_t              res_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    limits_t limits;
    bundle_t bundle;
    logic    load;
    logic    load_ok;

    // Configuration registers
    rlle_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // Input register and encoder
    rlle_core #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item),
        .limits    (limits),
        .load_ok   (load_ok),
        .load      (load),
        .bundle    (bundle)
    );

    // Result register and drain
    rlle_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bundle    (bundle),
        .load_ok   (load_ok),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

// ===== test/run_length_line_encoder_tb.sv =====
`timescale 1ns / 1ps

module run_length_line_encoder_tb;
    import rlle_pkg::*;

    localparam int LINE_W         = MAX_LINE_WIDTH_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_DIRECTED     = 24;
    localparam int PHASE_PIXELS   = 30;
    localparam int LONG_LINE      = 60;

    // Register index that maps to nothing; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(3);

    localparam out_item_t NO_WRITE = '0;

    // One row of the directed table: a pixel request and, where it is obvious,
    // the byte writes it must cause.
    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               eol;
        bit                 typed;
        int                 n_writes;
        out_item_t          w0;
        out_item_t          w1;
        out_item_t          w2;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      pix_valid = 1'b0;
    logic      pix_stall;
    in_item_t  pix_item  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int errors       = 0;
    int quiet_cycles = 0;

    // Writes still owed by the encoder, oldest first, and those of the last pixel.
    out_item_t due_writes[$];
    out_item_t pixel_writes[$];
    logic [PIXEL_W-1:0] line_buf[$];

    // Predictor copy of the configuration registers.
    logic [RUN_W-1:0]  max_run_q  = RUN_CAP;
    logic [TAIL_W-1:0] max_tail_q = 7'd127;

    // Predictor copy of the encoder state.
    logic [PIXEL_W-1:0]  pending_px[2] = '{8'd0, 8'd0};
    int                  pending_cnt   = 0;
    atom_mode_t          open_mode     = MODE_NONE;
    logic [OFFSET_W-1:0] open_head     = '0;
    logic [7:0]          open_len      = '0;
    logic [OFFSET_W-1:0] out_ptr       = '0;
    logic [PIXEL_W-1:0]  last_shade    = '0;
    int                  line_len      = 0;

    stim_row_t directed_rows[N_DIRECTED] = '{
        // Single pixel lines at both extremes of the index.
        '{8'hFF, 1'b1, 1'b1, 2, '{13'd1, 8'hFF, 1'b0, 13'd0},
          '{13'd0, 8'h01, 1'b1, 13'd2}, NO_WRITE},
        '{8'h00, 1'b1, 1'b1, 2, '{13'd1, 8'h00, 1'b0, 13'd0},
          '{13'd0, 8'h01, 1'b1, 13'd2}, NO_WRITE},
        // Two-pixel line: one literal atom of two shades.
        '{8'h00, 1'b0, 1'b1, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'hFF, 1'b1, 1'b1, 3, '{13'd1, 8'h00, 1'b0, 13'd0},
          '{13'd2, 8'hFF, 1'b0, 13'd0}, '{13'd0, 8'h02, 1'b1, 13'd3}},
        // Shortest run atom, which fills the whole line.
        '{8'hA5, 1'b0, 1'b1, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'hA5, 1'b0, 1'b1, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'hA5, 1'b1, 1'b1, 2, '{13'd1, 8'hA5, 1'b0, 13'd0},
          '{13'd0, 8'hFD, 1'b1, 13'd2}, NO_WRITE},
        // Literal, then a run, then an equal pair before the line end.
        '{8'h11, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h22, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h33, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h33, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h33, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h33, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h44, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h44, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h55, 1'b1, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        // Run first, closed by a single different pixel.
        '{8'h77, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h77, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h77, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h77, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h77, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h88, 1'b1, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        // Two equal pixels are too short for a run.
        '{8'h01, 1'b0, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE},
        '{8'h01, 1'b1, 1'b0, 0, NO_WRITE, NO_WRITE, NO_WRITE}
    };

    run_length_line_encoder #(
        .MAX_LINE_WIDTH(LINE_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_item(pix_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Effective limits after clamping the registers.
    function automatic int run_limit();
        if (max_run_q < RUN_MIN)
            return RUN_MIN;
        if (max_run_q > RUN_CAP)
            return RUN_CAP;
        return max_run_q;
    endfunction

    function automatic int tail_limit();
        if (max_tail_q < TAIL_MIN)
            return TAIL_MIN;
        return max_tail_q;
    endfunction

    function automatic void push_write(input logic [OFFSET_W-1:0] off,
                                       input logic [7:0] data,
                                       input logic done,
                                       input logic [OFFSET_W-1:0] total);
        out_item_t w;
        w.write_offset = off;
        w.write_byte   = data;
        w.line_done    = done;
        w.line_bytes   = total;
        pixel_writes.push_back(w);
    endfunction

    // Write the head byte of the open atom and leave no atom open.
    function automatic void close_atom(input logic done);
        logic [OFFSET_W-1:0] total;
        total = done ? out_ptr : '0;
        if (open_mode == MODE_RUN)
            push_write(open_head, 8'(9'd256 - open_len), done, total);
        else if (open_mode == MODE_LIT)
            push_write(open_head, open_len, done, total);
        open_mode = MODE_NONE;
        open_len  = '0;
    endfunction

    // Decide one pixel once its two successors, or the line end, are known.
    function automatic void take_pixel(input logic [PIXEL_W-1:0] c, input bit triple);
        if (open_mode == MODE_RUN)
        begin
            if (c == last_shade && open_len < run_limit())
            begin
                open_len++;
                return;
            end
            close_atom(1'b0);
        end
        else if (open_mode == MODE_LIT)
        begin
            if (!triple && open_len < tail_limit())
            begin
                push_write(out_ptr, c, 1'b0, '0);
                out_ptr++;
                open_len++;
                last_shade = c;
                return;
            end
            close_atom(1'b0);
        end
        // Open a new atom: room for its head, then the first value.
        open_head = out_ptr;
        push_write(out_ptr + 1'b1, c, 1'b0, '0);
        out_ptr   = out_ptr + 2'd2;
        open_len  = 8'd1;
        open_mode = triple ? MODE_RUN : MODE_LIT;
        last_shade = c;
    endfunction

    // Predict the byte writes caused by one accepted pixel request.
    function automatic void encode_pixel(input logic [PIXEL_W-1:0] px, input logic eol);
        logic [PIXEL_W-1:0] seq[3];
        int  n;
        bit  last;
        bit  triple;
        pixel_writes.delete();
        line_len++;
        last = eol || (line_len >= LINE_W);
        if (!last)
        begin
            if (pending_cnt < 2)
            begin
                pending_px[pending_cnt] = px;
                pending_cnt++;
                return;
            end
            take_pixel(pending_px[0], pending_px[0] == pending_px[1] && pending_px[0] == px);
            pending_px[0] = pending_px[1];
            pending_px[1] = px;
            return;
        end
        // Line end: flush the lookahead, never looking past the last pixel.
        n = 0;
        for (int k = 0; k < pending_cnt; k++)
        begin
            seq[n] = pending_px[k];
            n++;
        end
        seq[n] = px;
        n++;
        for (int k = 0; k < n; k++)
        begin
            triple = 1'b0;
            if (k + 2 < n)
                triple = (seq[k] == seq[k + 1]) && (seq[k] == seq[k + 2]);
            take_pixel(seq[k], triple);
        end
        close_atom(1'b1);
        pending_px  = '{8'd0, 8'd0};
        pending_cnt = 0;
        open_head   = '0;
        out_ptr     = '0;
        line_len    = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_MAX_RUN)
            max_run_q = data;
        else if (idx == CFG_MAX_TAIL)
            max_tail_q = data[TAIL_W-1:0];
    endfunction

    function automatic void commit_writes();
        foreach (pixel_writes[i])
            due_writes.push_back(pixel_writes[i]);
    endfunction

    // Offer one pixel request, with random idle cycles first, and predict it.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic eol);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pix_valid = 1'b0;
            @(negedge clk);
        end
        pix_valid            = 1'b1;
        pix_item.pixel       = px;
        pix_item.end_of_line = eol;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        encode_pixel(px, eol);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
        begin
            send_pixel(line_buf[i], i == line_buf.size() - 1);
            commit_writes();
        end
    endtask

    // Stop sending until every owed write has come, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        pix_valid = 1'b0;
        while (due_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Build and send one scanline: mostly short lines from a small palette, so
    // that runs and literals alternate, sometimes pure noise, and now and then
    // a run at or just over the current run limit.
    task automatic random_line();
        int                 len;
        bit                 noisy;
        logic [PIXEL_W-1:0] palette[3];
        logic [PIXEL_W-1:0] px;
        line_buf.delete();
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
        noisy = ($urandom_range(0, 3) == 0);
        foreach (palette[i])
            palette[i] = 8'($urandom_range(0, 255));
        px = palette[0];
        if ($urandom_range(0, 14) == 0)
        begin
            repeat ($urandom_range(0, 3))
                line_buf.push_back(8'($urandom_range(0, 255)));
            repeat (run_limit() + $urandom_range(0, 3))
                line_buf.push_back(px);
        end
        while (line_buf.size() < len)
        begin
            if (noisy)
                px = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) >= 55)
                px = palette[$urandom_range(0, 2)];
            line_buf.push_back(px);
        end
        send_line();
    endtask

    // One setting of the registers, the idling and the stalling, then random lines.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] run_val,
                             input logic [CFG_DATA_W-1:0] tail_val,
                             input int idle, input int stall, input int budget);
        int sent;
        wait_drained();
        write_reg(CFG_MAX_RUN, run_val);
        write_reg(CFG_MAX_TAIL, tail_val);
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < budget)
        begin
            // Sometimes hold the next line back until the encoder is empty.
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            random_line();
            sent += line_buf.size();
        end
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        res_stall = ($urandom_range(0, 99) < stall_pct);

    // Compare each accepted byte write with the oldest one owed.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_writes.size() == 0)
            begin
                $error("unexpected write: offset %0d byte %0h", res_item.write_offset,
                       res_item.write_byte);
                errors++;
            end
            else
            begin
                want = due_writes.pop_front();
                if (res_item.write_offset !== want.write_offset)
                begin
                    $error("write_offset: expected %0d, got %0d", want.write_offset,
                           res_item.write_offset);
                    errors++;
                end
                if (res_item.write_byte !== want.write_byte)
                begin
                    $error("write_byte: expected %0h, got %0h", want.write_byte,
                           res_item.write_byte);
                    errors++;
                end
                if (res_item.line_done !== want.line_done)
                begin
                    $error("line_done: expected %0b, got %0b", want.line_done,
                           res_item.line_done);
                    errors++;
                end
                if (res_item.line_bytes !== want.line_bytes)
                begin
                    $error("line_bytes: expected %0d, got %0d", want.line_bytes,
                           res_item.line_bytes);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any request moving means the encoder hangs.
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] prev;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset settings, no idling.
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_pixel(directed_rows[r].pixel, directed_rows[r].eol);
            if (!directed_rows[r].typed)
                commit_writes();
            else
            begin
                if (directed_rows[r].n_writes > 0)
                    due_writes.push_back(directed_rows[r].w0);
                if (directed_rows[r].n_writes > 1)
                    due_writes.push_back(directed_rows[r].w1);
                if (directed_rows[r].n_writes > 2)
                    due_writes.push_back(directed_rows[r].w2);
            end
        end

        // Random lines across register settings and idling patterns.
        run_phase(8'd3, 8'd1, 0, 0, PHASE_PIXELS);
        run_phase(8'd0, 8'd0, 71, 0, PHASE_PIXELS);
        run_phase(8'd255, 8'd127, 0, 71, PHASE_PIXELS);
        wait_drained();
        write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
        run_phase(8'd128, 8'd127, 20, 20, PHASE_PIXELS);
        run_phase(8'($urandom_range(3, 128)), 8'($urandom_range(1, 127)), 71, 0,
                  PHASE_PIXELS);
        run_phase(8'd4, 8'd2, 0, 71, PHASE_PIXELS);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 20, 20,
                  PHASE_PIXELS);
        run_phase(8'd2, 8'd127, 0, 0, PHASE_PIXELS);

        // Long line of single-shade literals: every pixel closes the previous
        // literal atom and opens a new one.
        wait_drained();
        write_reg(CFG_MAX_RUN, 8'(RUN_CAP));
        write_reg(CFG_MAX_TAIL, 8'(TAIL_MIN));
        idle_pct  = 0;
        stall_pct = 20;
        line_buf.delete();
        prev = '0;
        repeat (LONG_LINE)
        begin
            px = 8'($urandom_range(0, 255));
            if (px == prev)
                px = ~px;
            line_buf.push_back(px);
            prev = px;
        end
        send_line();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && due_writes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rlle_pkg.sv
rtl/rlle_config.sv
rtl/rlle_core.sv
rtl/rlle_out.sv
rtl/run_length_line_encoder.sv
test/run_length_line_encoder_tb.sv
